// ===== src/tcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants
// Field widths, register codes and the words handed along the pipeline.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int FIELD_W = 12;              // coordinate field width
    localparam int REG_W   = 13;              // size register width
    localparam int FLAT_W  = FIELD_W + REG_W; // flat index and dividend width
    localparam int DEF_MAX_DIM = 4096;
    localparam logic [REG_W-1:0] REG_RESET = 13'd4096;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_TILE,
        MODE_SIDE,
        MODE_BOTTOM
    } t_mode;

    // side info that rides along with the divider
    typedef struct packed {
        t_mode              mode;
        logic               inb;
        logic [1:0]         zx;
        logic [1:0]         zy;
        logic [FIELD_W-1:0] base;
    } t_ctl;

    // divider working word
    typedef struct packed {
        logic [REG_W-1:0]  rem;
        logic [FLAT_W-1:0] num;
        logic [REG_W-1:0]  den;
    } t_div;

endpackage
`default_nettype wire

// ===== src/tcs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_front: address setup
// Bounds check, flat index and region select; builds the divider operands.
// ----------------------------------------------------------------------------
module tcs_front #(
    parameter int MAX_DIM = tcs_pkg::DEF_MAX_DIM
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_en,
    input  wire                             i_valid,
    input  wire  [tcs_pkg::FIELD_W-1:0]     i_x,
    input  wire  [tcs_pkg::FIELD_W-1:0]     i_y,
    input  wire  [tcs_pkg::REG_W-1:0]       i_cfg_w,
    input  wire  [tcs_pkg::REG_W-1:0]       i_cfg_h,
    output logic                            o_valid,
    output tcs_pkg::t_ctl                   o_ctl,
    output tcs_pkg::t_div                   o_div
);
    import tcs_pkg::*;

    logic [REG_W-1:0]    w, h, bot_begin;
    logic [REG_W-3:0]    tiles_x, tiles_y;
    logic [2*REG_W-5:0]  tiles;             // full tile count

    // clamp to MAX_DIM
    always_comb begin
        w = ({{(32-REG_W){1'b0}}, i_cfg_w} > 32'(MAX_DIM)) ? REG_W'(MAX_DIM) : i_cfg_w;
        h = ({{(32-REG_W){1'b0}}, i_cfg_h} > 32'(MAX_DIM)) ? REG_W'(MAX_DIM) : i_cfg_h;
        tiles_x   = w[REG_W-1:2];
        tiles_y   = h[REG_W-1:2];
        tiles     = tiles_x * tiles_y;
        bot_begin = {h[REG_W-1:2], 2'b00};
    end

    // stage A: products and bounds
    logic                r_a_valid, r_a_inb, r_a_below;
    logic [FLAT_W-1:0]   r_a_prod;
    logic [FLAT_W:0]     r_a_side_begin, r_a_bot_off;
    logic [FIELD_W-1:0]  r_a_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_prod       <= i_y * w;
            r_a_side_begin <= {tiles, 4'b0000};
            r_a_bot_off    <= bot_begin * w;
            r_a_x          <= i_x;
            r_a_inb        <= ({1'b0, i_x} < w) && ({1'b0, i_y} < h);
            r_a_below      <= {1'b0, i_y} < bot_begin;
        end
    end

    // stage B: flat index
    logic                r_b_valid, r_b_inb, r_b_below;
    logic [FLAT_W-1:0]   r_b_flat;
    logic [FLAT_W:0]     r_b_side_begin, r_b_bot_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_flat       <= r_a_prod + FLAT_W'(r_a_x);
            r_b_side_begin <= r_a_side_begin;
            r_b_bot_off    <= r_a_bot_off;
            r_b_inb        <= r_a_inb;
            r_b_below      <= r_a_below;
        end
    end

    // stage C: region select
    t_ctl                n_ctl;
    t_div                n_div;
    logic [FLAT_W:0]     diff_side, diff_bot;

    always_comb begin
        diff_side    = {1'b0, r_b_flat} - r_b_side_begin;
        diff_bot     = {1'b0, r_b_flat} - r_b_bot_off;
        n_ctl.mode   = MODE_ZERO;
        n_ctl.inb    = r_b_inb;
        n_ctl.zx     = {r_b_flat[2], r_b_flat[0]};
        n_ctl.zy     = {r_b_flat[3], r_b_flat[1]};
        n_ctl.base   = '0;
        n_div.rem    = '0;
        n_div.num    = '0;
        n_div.den    = REG_W'(1);
        if (r_b_inb) begin
            if (r_b_below) begin
                if ({1'b0, r_b_flat} >= r_b_side_begin) begin
                    if (w[1:0] != 2'b00) begin
                        n_ctl.mode = MODE_SIDE;
                        n_ctl.base = FIELD_W'({w[REG_W-1:2], 2'b00});
                        n_div.num  = diff_side[FLAT_W-1:0];
                        n_div.den  = REG_W'(w[1:0]);
                    end
                end else if (tiles_x != '0) begin
                    n_ctl.mode = MODE_TILE;
                    n_div.num  = {4'b0000, r_b_flat[FLAT_W-1:4]};
                    n_div.den  = {2'b00, tiles_x};
                end
            end else begin
                // bottom strip height is never zero here
                n_ctl.mode = MODE_BOTTOM;
                n_ctl.base = FIELD_W'(bot_begin);
                n_div.num  = diff_bot[FLAT_W-1:0];
                n_div.den  = REG_W'(h[1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl <= n_ctl;
            o_div <= n_div;
        end
    end

endmodule
`default_nettype wire

// ===== src/tcs_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_div_cell: one restoring division step
// Shifts one dividend bit into the remainder and retires one quotient bit.
// ----------------------------------------------------------------------------
module tcs_div_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_valid,
    input  tcs_pkg::t_ctl     i_ctl,
    input  tcs_pkg::t_div     i_div,
    output logic              o_valid,
    output tcs_pkg::t_ctl     o_ctl,
    output tcs_pkg::t_div     o_div
);
    import tcs_pkg::*;

    logic [REG_W:0] sh, sub;
    logic           ge;
    t_div           n_div;

    always_comb begin
        sh        = {i_div.rem, i_div.num[FLAT_W-1]};
        sub       = sh - {1'b0, i_div.den};
        ge        = sh >= {1'b0, i_div.den};
        n_div.den = i_div.den;
        n_div.rem = ge ? sub[REG_W-1:0] : sh[REG_W-1:0];
        n_div.num = {i_div.num[FLAT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl <= i_ctl;
            o_div <= n_div;
        end
    end

endmodule
`default_nettype wire

// ===== src/tcs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_back: result assembly
// Forms the swizzled coordinate from quotient and remainder; output register.
// ----------------------------------------------------------------------------
module tcs_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  tcs_pkg::t_ctl                i_ctl,
    input  tcs_pkg::t_div                i_div,
    output logic                         o_valid,
    output logic [tcs_pkg::FIELD_W-1:0]  o_x,
    output logic [tcs_pkg::FIELD_W-1:0]  o_y,
    output logic                         o_inb
);
    import tcs_pkg::*;

    logic [FIELD_W-1:0] q, r, n_x, n_y;

    always_comb begin
        q   = i_div.num[FIELD_W-1:0];
        r   = i_div.rem[FIELD_W-1:0];
        n_x = '0;
        n_y = '0;
        unique case (i_ctl.mode)
            MODE_TILE: begin
                n_x = {r[FIELD_W-3:0], 2'b00} + FIELD_W'(i_ctl.zx);
                n_y = {q[FIELD_W-3:0], 2'b00} + FIELD_W'(i_ctl.zy);
            end
            MODE_SIDE: begin
                n_x = r + i_ctl.base;
                n_y = q;
            end
            MODE_BOTTOM: begin
                n_x = q;
                n_y = r + i_ctl.base;
            end
            default: begin
                n_x = '0;
                n_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x   <= n_x;
            o_y   <= n_y;
            o_inb <= i_ctl.inb;
        end
    end

endmodule
`default_nettype wire

// ===== src/tiled_coordinate_swizzle.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiled_coordinate_swizzle: tiled Z-order coordinate remap
// Maps a row-major (x, y) inside a width x height rectangle to its swizzled
// position: 4x4 tiles with 2x2 Z-order, right strip row-major, bottom strip
// column-major.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_in_x, i_in_y. A word is taken
//   on a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_out_x, o_out_y, o_in_bounds.
//   Config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index
//   selects width (0) or height (1), i_cfg_data is the 13-bit size. Write
//   only while the pipeline is empty; sizes above MAX_DIM saturate.
//   Throughput: one word per cycle unless stalled. Three setup stages, one
//   restoring divider cell per dividend bit, then the output register.
//   The divider chain sets the latency; every cell retires one quotient bit.
//   Stall: while the output holds a word and i_stall is high, the whole
//   pipeline freezes and o_stall is raised; no word is lost or repeated.
//   Reset: synchronous, active low; clears all valids and sets both sizes
//   to 4096.
// ----------------------------------------------------------------------------
module tiled_coordinate_swizzle #(
    parameter int MAX_DIM = tcs_pkg::DEF_MAX_DIM
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input words
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [tcs_pkg::FIELD_W-1:0]  i_in_x,
    input  wire  [tcs_pkg::FIELD_W-1:0]  i_in_y,
    // result words
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [tcs_pkg::FIELD_W-1:0]  o_out_x,
    output logic [tcs_pkg::FIELD_W-1:0]  o_out_y,
    output logic                         o_in_bounds,
    // config writes
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire                          i_cfg_index,
    input  wire  [tcs_pkg::REG_W-1:0]    i_cfg_data
);
    import tcs_pkg::*;

    logic [REG_W-1:0] r_width, r_height;
    logic             en;

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= REG_RESET;
            r_height <= REG_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // one global advance: freeze only when the output word is blocked
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    logic   v [FLAT_W+1];
    t_ctl   c [FLAT_W+1];
    t_div   d [FLAT_W+1];

    tcs_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_cfg_w (r_width),
        .i_cfg_h (r_height),
        .o_valid (v[0]),
        .o_ctl   (c[0]),
        .o_div   (d[0])
    );

    // divider chain: one cell per dividend bit, MSB first
    for (genvar g = 0; g < FLAT_W; g++) begin : g_cell
        tcs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_ctl   (c[g]),
            .i_div   (d[g]),
            .o_valid (v[g+1]),
            .o_ctl   (c[g+1]),
            .o_div   (d[g+1])
        );
    end

    tcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v[FLAT_W]),
        .i_ctl   (c[FLAT_W]),
        .i_div   (d[FLAT_W]),
        .o_valid (o_valid),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_inb   (o_in_bounds)
    );

endmodule
`default_nettype wire

// ===== src/tcs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_checker: port-level checks
// Watches the top-level ports of the swizzle block over time.
// ----------------------------------------------------------------------------
module tcs_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          o_stall,
    input  wire                          o_valid,
    input  wire                          i_stall,
    input  wire  [tcs_pkg::FIELD_W-1:0]  o_out_x,
    input  wire  [tcs_pkg::FIELD_W-1:0]  o_out_y,
    input  wire                          o_in_bounds
);
    import tcs_pkg::*;

    // a blocked result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_in_bounds))
        else $error("result word changed while stalled");

    // backpressure only comes from a blocked output
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without blocked output");

    // out of bounds gives zero coordinates
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_bounds |-> o_out_x == '0 && o_out_y == '0)
        else $error("out-of-bounds word with nonzero coordinates");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid result right after reset");

endmodule

bind tiled_coordinate_swizzle tcs_checker u_tcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_x     (o_out_x),
    .o_out_y     (o_out_y),
    .o_in_bounds (o_in_bounds)
);
`default_nettype wire
